@@ sv/osc_pkg.sv @@
// ----------------------------------------------------------------------------
// osc_pkg
// Shared types and constants of the oversampled sensor calibrator.
// ----------------------------------------------------------------------------
package osc_pkg;

  // Averaging window limits
  localparam logic [6:0] SAMPLES_MAX    = 7'd64;
  localparam logic [6:0] SAMPLES_MIN    = 7'd1;
  localparam logic [6:0] SAMPLES_RESET  = 7'd10;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_SAMPLES    = 2'd0;
  localparam logic [1:0] REG_GAIN       = 2'd1;
  localparam logic [1:0] REG_OFFSET     = 2'd2;

  // Quotient bits produced by each division pass
  localparam logic [4:0] NORM_STEPS     = 5'd17;
  localparam logic [4:0] QUOT_STEPS     = 5'd31;

  localparam logic [31:0] SAT_POS       = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG       = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_NORM_LD,
    ST_NORM,
    ST_DIFF,
    ST_PREP,
    ST_QUOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_cmd_t;

endpackage

@@ sv/osc_accum.sv @@
// ----------------------------------------------------------------------------
// osc_accum
// Running sample sum and count; flags the sample that closes a reading and
// holds the finished sum and sample count for the divider.
// ----------------------------------------------------------------------------
module osc_accum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [9:0]  sample,
  input  logic [6:0]  samples_per_reading,
  output logic        complete,
  output logic [15:0] hold_sum,
  output logic [6:0]  hold_n
);

  logic [15:0] sum_r, sum_nxt;
  logic [5:0]  taken_r, taken_nxt;
  logic [15:0] hold_sum_r, hold_sum_nxt;
  logic [6:0]  hold_n_r, hold_n_nxt;
  logic [15:0] sum_now;
  logic [6:0]  n_now;
  logic [6:0]  target;

  assign sum_now = sum_r + {6'b0, sample};
  assign n_now   = {1'b0, taken_r} + 7'd1;

  always_comb begin
    if (samples_per_reading < osc_pkg::SAMPLES_MIN) begin
      target = osc_pkg::SAMPLES_MIN;
    end else if (samples_per_reading > osc_pkg::SAMPLES_MAX) begin
      target = osc_pkg::SAMPLES_MAX;
    end else begin
      target = samples_per_reading;
    end
  end

  // A lowered window closes the reading on the next sample
  assign complete = (n_now >= target);

  always_comb begin
    sum_nxt      = sum_r;
    taken_nxt    = taken_r;
    hold_sum_nxt = hold_sum_r;
    hold_n_nxt   = hold_n_r;
    if (take) begin
      if (complete) begin
        sum_nxt      = '0;
        taken_nxt    = '0;
        hold_sum_nxt = sum_now;
        hold_n_nxt   = n_now;
      end else begin
        sum_nxt   = sum_now;
        taken_nxt = n_now[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      taken_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      taken_r <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_sum_r <= hold_sum_nxt;
    hold_n_r   <= hold_n_nxt;
  end

  assign hold_sum = hold_sum_r;
  assign hold_n   = hold_n_r;

endmodule

@@ sv/osc_serdiv.sv @@
// ----------------------------------------------------------------------------
// osc_serdiv
// Restoring divider, one quotient bit per cycle while cmd.step is set. Dividend bits shift out of
// the top of the quotient register while quotient bits shift in below.
// ----------------------------------------------------------------------------
module osc_serdiv (
  input  logic               clk,
  input  osc_pkg::div_cmd_t  cmd,
  input  logic [31:0]        rem_init,
  input  logic [30:0]        quo_init,
  input  logic [31:0]        divisor,
  output logic [30:0]        quo
);

  logic [31:0] rem_r, rem_nxt;
  logic [30:0] quo_r, quo_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  assign trial = {rem_r, quo_r[30]};
  assign diff  = trial - {1'b0, dv_r};
  assign fits  = (trial >= {1'b0, dv_r});

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dv_nxt  = dv_r;
    if (cmd.load) begin
      rem_nxt = rem_init;
      quo_nxt = quo_init;
      dv_nxt  = divisor;
    end else if (cmd.step) begin
      // remainder stays below the divisor, so 32 bits suffice
      rem_nxt = fits ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[29:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
  end

  assign quo = quo_r;

endmodule

@@ sv/oversampled_sensor_calibrator.sv @@
// ----------------------------------------------------------------------------
// oversampled_sensor_calibrator
// Averages converter samples and emits one calibrated Q16.16 reading per
// window: (sum / (n * 1023) - offset_coeff) / gain_coeff, truncated toward
// zero and saturated to 32 bits; a zero gain gives 0 with divide_error set.
// Samples that do not close a window are taken back to back. The sample
// that closes it starts a reading in the shared one-bit-per-cycle divider:
// 17 steps for the normalised average and 31 for the gain division
// (skipped when the result saturates; a zero gain skips both and goes
// straight to the output register). No sample is taken while a reading
// is in progress; one may be taken while a finished reading waits.
// ----------------------------------------------------------------------------
module oversampled_sensor_calibrator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_calibrated_value,
  output logic        out_divide_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  osc_pkg::state_t   state_r, state_nxt;
  osc_pkg::div_cmd_t div_cmd;

  logic [6:0]  spr_r, spr_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic [31:0] offset_r, offset_nxt;

  logic [4:0]  cnt_r, cnt_nxt;
  logic [33:0] diff_r, diff_nxt;
  logic        neg_r, neg_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_val_r, out_val_nxt;
  logic        out_err_r, out_err_nxt;

  logic        take;
  logic        complete;
  logic [15:0] hold_sum;
  logic [6:0]  hold_n;
  logic [16:0] n_scaled;
  logic [31:0] rem_init;
  logic [30:0] quo_init;
  logic [31:0] divisor;
  logic [30:0] quo;
  logic [33:0] diff_neg;
  logic [31:0] abs_diff;
  logic [31:0] abs_gain;
  logic        gain_zero;
  logic        out_load;
  logic [31:0] mag;
  logic [31:0] result;

  assign in_ready  = (state_r == osc_pkg::ST_ACC);
  assign take      = in_valid && in_ready;
  assign gain_zero = (gain_r == '0);
  assign out_load  = (state_r == osc_pkg::ST_DONE) && (!out_valid_r || out_ready);

  osc_accum u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .take                (take),
    .sample              (in_sample),
    .samples_per_reading (spr_r),
    .complete            (complete),
    .hold_sum            (hold_sum),
    .hold_n              (hold_n)
  );

  osc_serdiv u_div (
    .clk      (clk),
    .cmd      (div_cmd),
    .rem_init (rem_init),
    .quo_init (quo_init),
    .divisor  (divisor),
    .quo      (quo)
  );

  // n * 1023 as n * 1024 - n
  assign n_scaled = {hold_n, 10'b0} - {10'b0, hold_n};

  assign diff_neg = -diff_r;
  assign abs_diff = diff_r[33] ? diff_neg[31:0] : diff_r[31:0];
  assign abs_gain = gain_r[31] ? (-gain_r) : gain_r;

  // Saturation iff |diff| * 2^16 / |gain| >= 2^31, i.e. |diff| >= |gain| * 2^15
  assign ovf_nxt = (state_r == osc_pkg::ST_PREP) ?
                   ({15'b0, abs_diff} >= {abs_gain, 15'b0}) : ovf_r;

  always_comb begin
    if (state_r == osc_pkg::ST_NORM_LD) begin
      // sum * 2^16: top bits preload the remainder, the rest shifts in
      rem_init = {17'b0, hold_sum[15:1]};
      quo_init = {hold_sum[0], 30'b0};
      divisor  = {15'b0, n_scaled};
    end else begin
      rem_init = {15'b0, abs_diff[31:15]};
      quo_init = {abs_diff[14:0], 16'b0};
      divisor  = abs_gain;
    end
  end

  // Configuration writes
  always_comb begin
    spr_nxt    = spr_r;
    gain_nxt   = gain_r;
    offset_nxt = offset_r;
    if (cfg_we) begin
      unique case (cfg_index)
        osc_pkg::REG_SAMPLES: spr_nxt    = cfg_wdata[6:0];
        osc_pkg::REG_GAIN:    gain_nxt   = cfg_wdata;
        osc_pkg::REG_OFFSET:  offset_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      osc_pkg::ST_ACC: begin
        if (take && complete) begin
          state_nxt = gain_zero ? osc_pkg::ST_DONE : osc_pkg::ST_NORM_LD;
        end
      end
      osc_pkg::ST_NORM_LD: state_nxt = osc_pkg::ST_NORM;
      osc_pkg::ST_NORM: begin
        if (cnt_r == osc_pkg::NORM_STEPS - 5'd1) begin
          state_nxt = osc_pkg::ST_DIFF;
        end
      end
      osc_pkg::ST_DIFF: state_nxt = osc_pkg::ST_PREP;
      osc_pkg::ST_PREP: state_nxt = ovf_nxt ? osc_pkg::ST_DONE : osc_pkg::ST_QUOT;
      osc_pkg::ST_QUOT: begin
        if (cnt_r == osc_pkg::QUOT_STEPS - 5'd1) begin
          state_nxt = osc_pkg::ST_DONE;
        end
      end
      osc_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = osc_pkg::ST_ACC;
        end
      end
      default: state_nxt = osc_pkg::ST_ACC;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_cmd.load = 1'b0;
    div_cmd.step = 1'b0;
    cnt_nxt      = cnt_r;
    unique case (state_r) inside
      osc_pkg::ST_NORM_LD: begin
        div_cmd.load = 1'b1;
        cnt_nxt      = '0;
      end
      osc_pkg::ST_PREP: begin
        div_cmd.load = !ovf_nxt;
        cnt_nxt      = '0;
      end
      osc_pkg::ST_NORM, osc_pkg::ST_QUOT: begin
        div_cmd.step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
      end
      default: ;
    endcase
  end

  // Offset subtraction and quotient sign
  always_comb begin
    diff_nxt = diff_r;
    neg_nxt  = neg_r;
    if (state_r == osc_pkg::ST_DIFF) begin
      diff_nxt = {17'b0, quo[16:0]} - {{2{offset_r[31]}}, offset_r};
      neg_nxt  = diff_nxt[33] ^ gain_r[31];
    end
  end

  // Result formatting
  assign mag = {1'b0, quo};
  always_comb begin
    if (gain_zero) begin
      result = '0;
    end else if (ovf_r) begin
      result = neg_r ? osc_pkg::SAT_NEG : osc_pkg::SAT_POS;
    end else begin
      result = neg_r ? (-mag) : mag;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = result;
      out_err_nxt   = gain_zero;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= osc_pkg::ST_ACC;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      spr_r       <= osc_pkg::SAMPLES_RESET;
      gain_r      <= '0;
      offset_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      spr_r       <= spr_nxt;
      gain_r      <= gain_nxt;
      offset_r    <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r    <= diff_nxt;
    neg_r     <= neg_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_calibrated_value = out_val_r;
  assign out_divide_error     = out_err_r;

  // A divide error always carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_calibrated_value == '0)
    else $error("divide error with non-zero value");

  // The closing sample of a window starts a reading or goes straight to output
  a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take && complete |=> (state_r == osc_pkg::ST_NORM_LD) || (state_r == osc_pkg::ST_DONE))
    else $error("closing sample did not start a reading");

  // The gain division never runs once saturation has been detected
  a_quot_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == osc_pkg::ST_QUOT |-> !ovf_r)
    else $error("gain division running on a saturated reading");

  // Step counter stays within the normalisation pass length
  a_norm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == osc_pkg::ST_NORM |-> cnt_r < osc_pkg::NORM_STEPS)
    else $error("normalisation step count overrun");

endmodule
